// ===== rtl/core/tsp_pkg.sv =====
// Shared constants and types of the transport stream packetizer.
// No dependencies; every other file of the block refers to it by scoped names.
package tsp_pkg;

    // Packet geometry
    localparam int PAYLOAD_BYTES   = 184;
    localparam int HDR_BYTES       = 4;
    localparam int TS_BYTES        = PAYLOAD_BYTES + HDR_BYTES;
    localparam int WORD_BYTES      = 8;
    localparam int LAST_WORD_BYTES = TS_BYTES % WORD_BYTES;

    localparam int FILL_W  = 8;
    localparam int POS_W   = 8;
    localparam int LANE_W  = 3;
    localparam int CNT_W   = 4;
    localparam int PID_W   = 13;
    localparam int CC_W    = 4;

    localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(TS_BYTES - 1);
    localparam logic [POS_W-1:0]  HDR_LEN      = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0]  TS_LEN       = POS_W'(TS_BYTES);
    localparam logic [FILL_W-1:0] FULL_FILL    = FILL_W'(PAYLOAD_BYTES);
    localparam logic [FILL_W-1:0] SPLIT_FILL   = FILL_W'(PAYLOAD_BYTES - 1);
    localparam logic [FILL_W-1:0] SPLIT_FIRST  = FILL_W'(PAYLOAD_BYTES - 2);
    localparam logic [CNT_W-1:0]  FULL_COUNT   = CNT_W'(WORD_BYTES);
    localparam logic [CNT_W-1:0]  TAIL_COUNT   = CNT_W'(LAST_WORD_BYTES);

    // Header and adaptation field bytes
    localparam logic [7:0] SYNC_BYTE     = 8'h47;
    localparam logic [7:0] START_FLAG    = 8'h40;
    localparam logic [7:0] CTRL_AF_PL    = 8'h30;
    localparam logic [7:0] CTRL_PL       = 8'h10;
    localparam logic [7:0] PID_HI_MASK   = 8'h1F;
    localparam logic [7:0] AF_FLAGS      = 8'h00;
    localparam logic [7:0] STUFF_BYTE    = 8'hFF;

    // Byte positions inside the header and adaptation field
    localparam logic [POS_W-1:0] POS_SYNC    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_PID_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PID_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CTRL    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_AF_LEN  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_AF_FLAG = POS_W'(5);
    localparam logic [POS_W-1:0] AF_LEN_BIAS = POS_W'(HDR_BYTES + 1);

    // Register map
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam logic [ADDR_W-3:0] REG_STREAM_PID = '0;
    localparam logic [PID_W-1:0]  PID_RESET      = PID_W'(256);

    // Packet request from the input side to the framer
    typedef struct packed {
        logic              start;
        logic [FILL_W-1:0] count;
        logic              ends_unit;
        logic              split;
    } tsp_job_t;

    // Framer status back to the input side
    typedef struct packed {
        logic active;
        logic done;
    } tsp_stat_t;

endpackage

// ===== rtl/core/ts_packetizer_core.sv =====
// Transport stream packetizer. Input bytes are taken at one per cycle into a
// 184-byte payload memory. When the memory fills, or a byte marked unit_last
// arrives, the byte channel stalls while the framer walks the packet, one byte
// position per cycle unless the output stalls, reading payload bytes from the
// memory's single read port; a 183-byte tail goes out as two packets. Each word
// passes from the issue stage through the byte stage to the output register.
// Output stall freezes the framer. The stream PID is register 0
// (byte address 0) on the APB port.
module ts_packetizer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [tsp_pkg::DATA_W-1:0]    pwdata,
    output logic [tsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // PES byte channel
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          unit_last,
    // Packet word channel
    output logic                          word_valid,
    input  logic                          word_stall,
    output logic [63:0]                   packet_word,
    output logic [tsp_pkg::CNT_W-1:0]     valid_bytes,
    output logic                          packet_end,
    output logic                          unit_end
);

    logic [tsp_pkg::PID_W-1:0]    stream_pid;
    logic [tsp_pkg::FILL_W-1:0]   fill_reg,  fill_next;
    logic                         busy_reg,  busy_next;
    logic [tsp_pkg::FILL_W-1:0]   fill_plus;
    logic                         accept;
    logic                         full;
    logic                         trigger;
    tsp_pkg::tsp_job_t            job;
    tsp_pkg::tsp_stat_t           stat;
    logic                         rd_en;
    logic [tsp_pkg::FILL_W-1:0]   rd_addr;
    logic [7:0]                   rd_data;

    tsp_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .stream_pid (stream_pid)
    );

    assign accept    = byte_valid && !byte_stall;
    assign fill_plus = fill_reg + 1'b1;
    assign full      = (fill_plus == tsp_pkg::FULL_FILL);
    assign trigger   = full || unit_last;

    always_comb
    begin
        job.start     = accept && trigger;
        job.ends_unit = unit_last;
        job.split     = !full && unit_last && (fill_plus == tsp_pkg::SPLIT_FILL);
        job.count     = job.split ? tsp_pkg::SPLIT_FIRST : fill_plus;
    end

    always_comb
    begin
        fill_next = fill_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            fill_next = trigger ? '0 : fill_plus;
            busy_next = trigger;
        end
        else if (stat.done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

    // Hold the byte channel while a packet is being framed
    assign byte_stall = busy_reg;

    tsp_store u_store
    (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (fill_reg),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsp_framer u_framer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .stat        (stat),
        .stream_pid  (stream_pid),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .packet_word (packet_word),
        .valid_bytes (valid_bytes),
        .packet_end  (packet_end),
        .unit_end    (unit_end)
    );

`ifndef ASSERT_OFF
    a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < tsp_pkg::FULL_FILL)
        else $error("fill count beyond payload size");

    a_framer_busy : assert property (@(posedge clk) disable iff (!rst_n)
        stat.active |-> busy_reg)
        else $error("framer active while byte channel open");

    a_last_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && unit_last) |=> byte_stall)
        else $error("unit end did not start a packet");

    a_end_count : assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && packet_end) |-> (valid_bytes == tsp_pkg::TAIL_COUNT))
        else $error("packet end word with wrong byte count");
`endif

endmodule

// ===== rtl/core/tsp_cfg.sv =====
// APB register file of the packetizer: holds the stream PID.
// Depends on tsp_pkg for the register map and reset value.
module tsp_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsp_pkg::DATA_W-1:0]   pwdata,
    output logic [tsp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [tsp_pkg::PID_W-1:0]    stream_pid
);

    logic [tsp_pkg::PID_W-1:0]    pid_reg;
    logic [tsp_pkg::PID_W-1:0]    pid_next;
    logic [tsp_pkg::ADDR_W-3:0]   reg_idx;
    logic                         wr_en;

    assign reg_idx = paddr[tsp_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        pid_next = pid_reg;
        if (wr_en && (reg_idx == tsp_pkg::REG_STREAM_PID))
        begin
            pid_next = pwdata[tsp_pkg::PID_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == tsp_pkg::REG_STREAM_PID)
        begin
            prdata = tsp_pkg::DATA_W'(pid_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg <= tsp_pkg::PID_RESET;
        end
        else
        begin
            pid_reg <= pid_next;
        end
    end

    assign stream_pid = pid_reg;

endmodule

// ===== rtl/core/tsp_store.sv =====
// Payload store: one byte-wide synchronous memory, one write and one read port.
// Read data is registered and holds while the read enable is low. Uses tsp_pkg.
module tsp_store
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [tsp_pkg::FILL_W-1:0]    wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [tsp_pkg::FILL_W-1:0]    rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [tsp_pkg::PAYLOAD_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tsp_framer.sv =====
// Packet framer: walks the 188 byte positions of a packet, reads payload from
// the store, merges header and adaptation bytes, and packs 64-bit words.
// Depends on tsp_pkg; reads the store through its registered read port.
module tsp_framer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsp_pkg::tsp_job_t             job,
    output tsp_pkg::tsp_stat_t            stat,
    input  logic [tsp_pkg::PID_W-1:0]     stream_pid,
    output logic                          rd_en,
    output logic [tsp_pkg::FILL_W-1:0]    rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          word_valid,
    input  logic                          word_stall,
    output logic [63:0]                   packet_word,
    output logic [tsp_pkg::CNT_W-1:0]     valid_bytes,
    output logic                          packet_end,
    output logic                          unit_end
);

    // Issue stage
    logic                          active_reg,  active_next;
    logic                          split_reg,   split_next;
    logic                          ends_reg,    ends_next;
    logic                          spend_reg,   spend_next;
    logic [tsp_pkg::CC_W-1:0]      cc_reg,      cc_next;
    logic [tsp_pkg::POS_W-1:0]     pos_reg,     pos_next;
    logic [tsp_pkg::POS_W-1:0]     dstart_reg,  dstart_next;
    logic [tsp_pkg::FILL_W-1:0]    src_reg,     src_next;

    // Byte stage
    logic                          bv_reg,      bv_next;
    logic                          bmem_reg;
    logic                          blast_reg;
    logic                          bends_reg;
    logic [7:0]                    bconst_reg;

    // Word assembly and output register
    logic [tsp_pkg::LANE_W-1:0]    lane_reg,    lane_next;
    logic [63:0]                   acc_reg;
    logic [63:0]                   acc_next;
    logic                          ov_reg,      ov_next;
    logic [63:0]                   oword_reg;
    logic [tsp_pkg::CNT_W-1:0]     ocnt_reg;
    logic                          opend_reg;
    logic                          ouend_reg;

    logic                          advance;
    logic                          issue;
    logic                          pkt_last;
    logic                          adapt;
    logic                          use_mem;
    logic [7:0]                    hdr_byte;
    logic [7:0]                    cur_byte;
    logic                          take;
    logic                          word_done;
    logic                          done_pulse;

    // The whole pipeline freezes while a finished word waits on the output
    assign advance  = !(ov_reg && word_stall);
    assign issue    = advance && active_reg;
    assign pkt_last = (pos_reg == tsp_pkg::LAST_POS);
    assign adapt    = (dstart_reg != tsp_pkg::HDR_LEN);
    assign use_mem  = (pos_reg >= dstart_reg);

    assign rd_en    = issue && use_mem;
    assign rd_addr  = pos_reg - dstart_reg + src_reg;

    // Header, adaptation field and stuffing bytes
    always_comb
    begin
        hdr_byte = tsp_pkg::STUFF_BYTE;
        if (pos_reg == tsp_pkg::POS_SYNC)
        begin
            hdr_byte = tsp_pkg::SYNC_BYTE;
        end
        else if (pos_reg == tsp_pkg::POS_PID_HI)
        begin
            hdr_byte = (spend_reg ? tsp_pkg::START_FLAG : 8'h00)
                     | (8'(stream_pid >> 8) & tsp_pkg::PID_HI_MASK);
        end
        else if (pos_reg == tsp_pkg::POS_PID_LO)
        begin
            hdr_byte = stream_pid[7:0];
        end
        else if (pos_reg == tsp_pkg::POS_CTRL)
        begin
            hdr_byte = (adapt ? tsp_pkg::CTRL_AF_PL : tsp_pkg::CTRL_PL) | 8'(cc_reg);
        end
        else if (adapt && (pos_reg == tsp_pkg::POS_AF_LEN))
        begin
            hdr_byte = dstart_reg - tsp_pkg::AF_LEN_BIAS;
        end
        else if (adapt && (pos_reg == tsp_pkg::POS_AF_FLAG))
        begin
            hdr_byte = tsp_pkg::AF_FLAGS;
        end
    end

    // Packet sequencing
    always_comb
    begin
        active_next = active_reg;
        split_next  = split_reg;
        ends_next   = ends_reg;
        spend_next  = spend_reg;
        cc_next     = cc_reg;
        pos_next    = pos_reg;
        dstart_next = dstart_reg;
        src_next    = src_reg;
        done_pulse  = 1'b0;
        if (job.start)
        begin
            active_next = 1'b1;
            split_next  = job.split;
            ends_next   = job.ends_unit && !job.split;
            pos_next    = '0;
            dstart_next = tsp_pkg::TS_LEN - job.count;
            src_next    = '0;
        end
        else if (issue)
        begin
            pos_next = pos_reg + 1'b1;
            if (pkt_last)
            begin
                cc_next    = cc_reg + 1'b1;
                spend_next = ends_reg;
                pos_next   = '0;
                if (split_reg)
                begin
                    // Second packet of a split tail: the single last byte
                    split_next  = 1'b0;
                    ends_next   = 1'b1;
                    dstart_next = tsp_pkg::LAST_POS;
                    src_next    = tsp_pkg::SPLIT_FIRST;
                end
                else
                begin
                    active_next = 1'b0;
                    done_pulse  = 1'b1;
                end
            end
        end
    end

    assign stat.active = active_reg;
    assign stat.done   = done_pulse;

    assign bv_next  = advance ? active_reg : bv_reg;
    assign cur_byte = bmem_reg ? rd_data : bconst_reg;
    assign take     = advance && bv_reg;
    assign word_done = take && ((lane_reg == '1) || blast_reg);

    // Place the byte in its lane; a fresh word starts from zero
    always_comb
    begin
        acc_next = (lane_reg == '0) ? 64'h0 : acc_reg;
        acc_next[63 - 8*lane_reg -: 8] = cur_byte;
    end

    always_comb
    begin
        lane_next = lane_reg;
        if (take)
        begin
            lane_next = blast_reg ? '0 : lane_reg + 1'b1;
        end
    end

    assign ov_next = advance ? word_done : ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            split_reg  <= 1'b0;
            ends_reg   <= 1'b0;
            spend_reg  <= 1'b1;
            cc_reg     <= '0;
            pos_reg    <= '0;
            bv_reg     <= 1'b0;
            lane_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            split_reg  <= split_next;
            ends_reg   <= ends_next;
            spend_reg  <= spend_next;
            cc_reg     <= cc_next;
            pos_reg    <= pos_next;
            bv_reg     <= bv_next;
            lane_reg   <= lane_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dstart_reg <= dstart_next;
        src_reg    <= src_next;
        if (issue)
        begin
            bmem_reg   <= use_mem;
            blast_reg  <= pkt_last;
            bends_reg  <= ends_reg;
            bconst_reg <= hdr_byte;
        end
        if (take)
        begin
            acc_reg <= acc_next;
        end
        if (word_done)
        begin
            oword_reg <= acc_next;
            ocnt_reg  <= blast_reg ? tsp_pkg::TAIL_COUNT : tsp_pkg::FULL_COUNT;
            opend_reg <= blast_reg;
            ouend_reg <= blast_reg && bends_reg;
        end
    end

    assign word_valid  = ov_reg;
    assign packet_word = oword_reg;
    assign valid_bytes = ocnt_reg;
    assign packet_end  = opend_reg;
    assign unit_end    = ouend_reg;

endmodule
